>>> rtl/lidar_point_to_pixel_projector_defines.svh
// ----------------------------------------------------------------------------
// Lidar point to pixel projector assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_TO_PIXEL_PROJECTOR_DEFINES_SVH
`define LIDAR_POINT_TO_PIXEL_PROJECTOR_DEFINES_SVH

`ifndef SYNTH
`define LPPP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lppp assertion failed");
`define LPPP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lppp reset assertion failed");
`else
`define LPPP_ASSERT(label, prop)
`define LPPP_ASSERT_RST(label, prop)
`endif

`endif

>>> rtl/lppp_pkg.sv
// ----------------------------------------------------------------------------
// Lidar point to pixel projector package
// Widths and register indexes shared by the projector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lppp_pkg;

    localparam int PW = 20;
    localparam int CW = 38;
    localparam int NW = 52;
    localparam int QW = 16;
    localparam int RW = 48;
    localparam int IW = 3;

    localparam logic [IW-1:0] REG_ROT_ROW0       = 3'd0;
    localparam logic [IW-1:0] REG_ROT_ROW1       = 3'd1;
    localparam logic [IW-1:0] REG_ROT_ROW2       = 3'd2;
    localparam logic [IW-1:0] REG_TRANSLATION    = 3'd3;
    localparam logic [IW-1:0] REG_FOCAL_LENGTH   = 3'd4;
    localparam logic [IW-1:0] REG_PRINCIPAL_PT   = 3'd5;

endpackage

`default_nettype wire

>>> rtl/lppp_rotate.sv
// ----------------------------------------------------------------------------
// Lidar point to pixel projector: extrinsic transform
// Remaps the axes, multiplies by the rotation matrix and adds the translation.
// ----------------------------------------------------------------------------
`default_nettype none

module lppp_rotate (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic signed [lppp_pkg::PW-1:0]  point_x,
    input  wire logic signed [lppp_pkg::PW-1:0]  point_y,
    input  wire logic signed [lppp_pkg::PW-1:0]  point_z,
    input  wire logic        [lppp_pkg::RW-1:0]  rot_row0,
    input  wire logic        [lppp_pkg::RW-1:0]  rot_row1,
    input  wire logic        [lppp_pkg::RW-1:0]  rot_row2,
    input  wire logic        [lppp_pkg::RW-1:0]  translation,
    output logic                                 out_valid,
    output logic signed      [lppp_pkg::CW-1:0]  cam0,
    output logic signed      [lppp_pkg::CW-1:0]  cam1,
    output logic signed      [lppp_pkg::CW-1:0]  cam2
);
    import lppp_pkg::*;

    logic signed [20:0]   a_vec [3];
    logic [RW-1:0]        rows [3];
    logic signed [36:0]   prod_next [3][3];
    logic signed [36:0]   prod_reg  [3][3];
    logic signed [29:0]   trans_next [3];
    logic signed [29:0]   trans_reg  [3];
    logic signed [CW-1:0] cam_next [3];
    logic signed [CW-1:0] cam_reg  [3];
    logic                 v1_reg;
    logic                 v2_reg;

    always_comb
    begin
        a_vec[0] = -21'(point_y);
        a_vec[1] = -21'(point_z);
        a_vec[2] = 21'(point_x);
        rows[0] = rot_row0;
        rows[1] = rot_row1;
        rows[2] = rot_row2;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[r][k] = 37'($signed(rows[r][16*k +: 16])) * 37'(a_vec[k]);
            end
            trans_next[r] = $signed({translation[16*r +: 16], 14'b0});
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            cam_next[r] = CW'(prod_reg[r][0]) + CW'(prod_reg[r][1])
                        + CW'(prod_reg[r][2]) + CW'(trans_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
            cam_reg   <= cam_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign cam0 = cam_reg[0];
    assign cam1 = cam_reg[1];
    assign cam2 = cam_reg[2];

endmodule

`default_nettype wire

>>> rtl/lppp_numer.sv
// ----------------------------------------------------------------------------
// Lidar point to pixel projector: intrinsic numerators
// Forms f*c0 + pu*c2 and f*c1 + pv*c2 over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lppp_numer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic signed [lppp_pkg::CW-1:0]  cam0,
    input  wire logic signed [lppp_pkg::CW-1:0]  cam1,
    input  wire logic signed [lppp_pkg::CW-1:0]  cam2,
    input  wire logic        [11:0]              focal_length,
    input  wire logic        [23:0]              principal_point,
    output logic                                 out_valid,
    output logic signed      [lppp_pkg::NW-1:0]  num_u,
    output logic signed      [lppp_pkg::NW-1:0]  num_v,
    output logic signed      [lppp_pkg::CW-1:0]  depth
);
    import lppp_pkg::*;

    localparam int MW = 51;

    logic signed [12:0]   f_s;
    logic signed [12:0]   pu_s;
    logic signed [12:0]   pv_s;
    logic signed [MW-1:0] fu_reg;
    logic signed [MW-1:0] fv_reg;
    logic signed [MW-1:0] pu_reg;
    logic signed [MW-1:0] pv_reg;
    logic signed [CW-1:0] d1_reg;
    logic signed [NW-1:0] nu_reg;
    logic signed [NW-1:0] nv_reg;
    logic signed [CW-1:0] d2_reg;
    logic                 v1_reg;
    logic                 v2_reg;

    assign f_s  = $signed({1'b0, focal_length});
    assign pu_s = $signed({1'b0, principal_point[11:0]});
    assign pv_s = $signed({1'b0, principal_point[23:12]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fu_reg <= MW'(f_s) * MW'(cam0);
            fv_reg <= MW'(f_s) * MW'(cam1);
            pu_reg <= MW'(pu_s) * MW'(cam2);
            pv_reg <= MW'(pv_s) * MW'(cam2);
            d1_reg <= cam2;
            nu_reg <= NW'(fu_reg) + NW'(pu_reg);
            nv_reg <= NW'(fv_reg) + NW'(pv_reg);
            d2_reg <= d1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign num_u = nu_reg;
    assign num_v = nv_reg;
    assign depth = d2_reg;

endmodule

`default_nettype wire

>>> rtl/lppp_div.sv
// ----------------------------------------------------------------------------
// Lidar point to pixel projector: pipelined divider
// Restoring division of both numerators by depth, two quotient bits a stage,
// followed by sign restore, saturation and the zero depth override.
// ----------------------------------------------------------------------------
`default_nettype none

module lppp_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic signed [lppp_pkg::NW-1:0]  num_u,
    input  wire logic signed [lppp_pkg::NW-1:0]  num_v,
    input  wire logic signed [lppp_pkg::CW-1:0]  depth,
    output logic                                 out_valid,
    output logic             [lppp_pkg::QW-1:0]  pixel_u,
    output logic             [lppp_pkg::QW-1:0]  pixel_v,
    output logic                                 zero_depth
);
    import lppp_pkg::*;

    localparam int NS = QW / 2;

    logic [NW-1:0]   rem_reg  [NS+1][2];
    logic [QW-1:0]   quo_reg  [NS+1][2];
    logic            neg_reg  [NS+1][2];
    logic            ovf_reg  [NS+1][2];
    logic [CW-1:0]   den_reg  [NS+1];
    logic            zero_reg [NS+1];
    logic            val_reg  [NS+1];

    logic [NW-1:0]   nabs [2];
    logic [CW-1:0]   dabs;
    logic signed [NW-1:0] nums [2];
    logic [QW-1:0]   sat_next [2];
    logic [QW-1:0]   pix_reg [2];
    logic            zout_reg;
    logic            vout_reg;

    always_comb
    begin
        nums[0] = num_u;
        nums[1] = num_v;
        dabs = depth[CW-1] ? CW'(-depth) : CW'(depth);
        for (int l = 0; l < 2; l++)
        begin
            nabs[l] = nums[l][NW-1] ? NW'(-nums[l]) : NW'(nums[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= nabs[l];
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= nums[l][NW-1] ^ depth[CW-1];
                ovf_reg[0][l] <= (54'(nabs[l]) >= {dabs, 16'b0});
            end
            den_reg[0]  <= dabs;
            zero_reg[0] <= (depth == '0);
        end
    end

    for (genvar s = 1; s <= NS; s++)
    begin : g_step
        localparam int HI = QW + 1 - 2 * s;
        logic [NW-1:0] r_mid [2];
        logic [NW-1:0] r_end [2];
        logic [QW-1:0] q_end [2];
        logic [53:0]   d_hi;
        logic [53:0]   d_lo;

        always_comb
        begin
            d_hi = 54'(den_reg[s-1]) << HI;
            d_lo = 54'(den_reg[s-1]) << (HI - 1);
            for (int l = 0; l < 2; l++)
            begin
                q_end[l] = quo_reg[s-1][l];
                r_mid[l] = rem_reg[s-1][l];
                if (54'(rem_reg[s-1][l]) >= d_hi)
                begin
                    r_mid[l] = NW'(54'(rem_reg[s-1][l]) - d_hi);
                    q_end[l][HI] = 1'b1;
                end
                r_end[l] = r_mid[l];
                if (54'(r_mid[l]) >= d_lo)
                begin
                    r_end[l] = NW'(54'(r_mid[l]) - d_lo);
                    q_end[l][HI-1] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[s][l] <= r_end[l];
                    quo_reg[s][l] <= q_end[l];
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                end
                den_reg[s]  <= den_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[s] <= val_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
            vout_reg   <= 1'b0;
        end
        else if (en)
        begin
            val_reg[0] <= in_valid;
            vout_reg   <= val_reg[NS];
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (zero_reg[NS])
            begin
                sat_next[l] = '0;
            end
            else if (neg_reg[NS][l])
            begin
                if (ovf_reg[NS][l] || (quo_reg[NS][l] > 16'h8000))
                begin
                    sat_next[l] = 16'h8000;
                end
                else
                begin
                    sat_next[l] = QW'(-quo_reg[NS][l]);
                end
            end
            else
            begin
                if (ovf_reg[NS][l] || (quo_reg[NS][l] > 16'h7FFF))
                begin
                    sat_next[l] = 16'h7FFF;
                end
                else
                begin
                    sat_next[l] = quo_reg[NS][l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg  <= sat_next;
            zout_reg <= zero_reg[NS];
        end
    end

    assign out_valid  = vout_reg;
    assign pixel_u    = pix_reg[0];
    assign pixel_v    = pix_reg[1];
    assign zero_depth = zout_reg;

endmodule

`default_nettype wire

>>> rtl/lidar_point_to_pixel_projector.sv
// ----------------------------------------------------------------------------
// Lidar point to pixel projector
// Projects lidar points into camera pixel coordinates through a fixed-point
// pinhole model with software-loaded extrinsics and intrinsics.
//
//   Channel    Direction  Payload
//   s_axis     in         point_x, point_y, point_z
//   m_axis     out        pixel_u, pixel_v; tuser zero_depth
//   cfg        in         register index and write data
//
// One point is taken every cycle while the output is not stalled. The
// pipeline has fourteen register stages: two transform stages, two numerator
// stages and the ten-stage divider. The first stage loads at the input
// transfer edge, and each result is presented from the divider output
// register. Reset loads the default calibration and empties the pipeline.
// When the output stalls, the whole pipeline holds in place.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_point_to_pixel_projector_defines.svh"

module lidar_point_to_pixel_projector (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [63:0]                s_axis_tdata,  // point_x, point_y, point_z
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // pixel_u, pixel_v
    output logic                            m_axis_tuser,  // zero_depth
    input  wire logic                       cfg_wen,
    input  wire logic [lppp_pkg::IW-1:0]    cfg_index,
    input  wire logic [lppp_pkg::RW-1:0]    cfg_wdata
);
    import lppp_pkg::*;

    logic [RW-1:0]        rot0_reg;
    logic [RW-1:0]        rot1_reg;
    logic [RW-1:0]        rot2_reg;
    logic [RW-1:0]        trans_reg;
    logic [11:0]          focal_reg;
    logic [23:0]          pp_reg;

    logic                 en;
    logic                 rot_valid;
    logic signed [CW-1:0] cam0;
    logic signed [CW-1:0] cam1;
    logic signed [CW-1:0] cam2;
    logic                 num_valid;
    logic signed [NW-1:0] num_u;
    logic signed [NW-1:0] num_v;
    logic signed [CW-1:0] depth;
    logic [QW-1:0]        pixel_u;
    logic [QW-1:0]        pixel_v;
    logic                 zero_depth;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot0_reg  <= 48'h4000_0000_0000;
            rot1_reg  <= 48'h0000_4000_0000;
            rot2_reg  <= 48'h0000_0000_4000;
            trans_reg <= '0;
            focal_reg <= 12'd579;
            pp_reg    <= 24'd786736;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ROT_ROW0:     rot0_reg  <= cfg_wdata;
                REG_ROT_ROW1:     rot1_reg  <= cfg_wdata;
                REG_ROT_ROW2:     rot2_reg  <= cfg_wdata;
                REG_TRANSLATION:  trans_reg <= cfg_wdata;
                REG_FOCAL_LENGTH: focal_reg <= cfg_wdata[11:0];
                REG_PRINCIPAL_PT: pp_reg    <= cfg_wdata[23:0];
                default:          ;
            endcase
        end
    end

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    lppp_rotate u_rotate (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .point_x     ($signed(s_axis_tdata[19:0])),
        .point_y     ($signed(s_axis_tdata[39:20])),
        .point_z     ($signed(s_axis_tdata[59:40])),
        .rot_row0    (rot0_reg),
        .rot_row1    (rot1_reg),
        .rot_row2    (rot2_reg),
        .translation (trans_reg),
        .out_valid   (rot_valid),
        .cam0        (cam0),
        .cam1        (cam1),
        .cam2        (cam2)
    );

    lppp_numer u_numer (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (rot_valid),
        .cam0            (cam0),
        .cam1            (cam1),
        .cam2            (cam2),
        .focal_length    (focal_reg),
        .principal_point (pp_reg),
        .out_valid       (num_valid),
        .num_u           (num_u),
        .num_v           (num_v),
        .depth           (depth)
    );

    lppp_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (num_valid),
        .num_u      (num_u),
        .num_v      (num_v),
        .depth      (depth),
        .out_valid  (m_axis_tvalid),
        .pixel_u    (pixel_u),
        .pixel_v    (pixel_v),
        .zero_depth (zero_depth)
    );

    assign m_axis_tdata = {pixel_v, pixel_u};
    assign m_axis_tuser = zero_depth;

    `LPPP_ASSERT(a_zero_depth_clears, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    `LPPP_ASSERT(a_stall_holds_input, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    `LPPP_ASSERT_RST(a_reset_empty, !rst_n |=> !m_axis_tvalid)

endmodule

`default_nettype wire

>>> sim/lidar_point_to_pixel_projector_test.sv
// ----------------------------------------------------------------------------
// Lidar point to pixel projector testbench
// Drives lidar points through the stream input, predicts each pixel result
// with an independent fixed-point projection, and compares every output
// transfer against the oldest prediction under random idling and stalls.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_projector_test;
    import lppp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
        logic        zd;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_wen = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [RW-1:0] cfg_wdata = '0;

    logic [47:0] rot0, rot1, rot2, trans;
    logic [11:0] focal;
    logic [23:0] ppoint;

    pixel_t pending_pixels[$];
    int errors = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    int rx_wait = 0;
    bit rx_random = 1'b1;

    always #1 clk = ~clk;

    lidar_point_to_pixel_projector dut (.*);

    function automatic logic signed [63:0] lane(logic [47:0] r, int k);
        return 64'(signed'(r[16*k +: 16]));
    endfunction

    function automatic logic [15:0] clamp16(logic signed [63:0] q);
        if (q > 32767) return 16'h7fff;
        if (q < -32768) return 16'h8000;
        return q[15:0];
    endfunction

    function automatic pixel_t project_point(logic [19:0] px, logic [19:0] py,
                                             logic [19:0] pz);
        logic signed [63:0] a0, a1, a2, c0, c1, c2, nu, nv;
        pixel_t p;
        a0 = -64'(signed'(py));
        a1 = -64'(signed'(pz));
        a2 = 64'(signed'(px));
        c0 = lane(rot0, 0) * a0 + lane(rot0, 1) * a1 + lane(rot0, 2) * a2
             + lane(trans, 0) * 16384;
        c1 = lane(rot1, 0) * a0 + lane(rot1, 1) * a1 + lane(rot1, 2) * a2
             + lane(trans, 1) * 16384;
        c2 = lane(rot2, 0) * a0 + lane(rot2, 1) * a1 + lane(rot2, 2) * a2
             + lane(trans, 2) * 16384;
        if (c2 == 0)
        begin
            p = '{16'd0, 16'd0, 1'b1};
        end
        else
        begin
            nu = $signed({52'd0, focal}) * c0 + $signed({52'd0, ppoint[11:0]}) * c2;
            nv = $signed({52'd0, focal}) * c1 + $signed({52'd0, ppoint[23:12]}) * c2;
            p = '{clamp16(nu / c2), clamp16(nv / c2), 1'b0};
        end
        return p;
    endfunction

    task automatic write_reg(logic [IW-1:0] idx, logic [RW-1:0] val);
        @(negedge clk);
        cfg_wen = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wen = 1'b0;
        case (idx)
            REG_ROT_ROW0: rot0 = val;
            REG_ROT_ROW1: rot1 = val;
            REG_ROT_ROW2: rot2 = val;
            REG_TRANSLATION: trans = val;
            REG_FOCAL_LENGTH: focal = val[11:0];
            REG_PRINCIPAL_PT: ppoint = val[23:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        wait (pending_pixels.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz,
                              bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        s_axis_tdata = {4'd0, pz, py, px};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_pixels.push_back(project_point(px, py, pz));
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [19:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 20'h80000;
            1: return 20'h7ffff;
            2: return 20'($signed($urandom_range(0, 8191)) - 4096);
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_rot();
        case ($urandom_range(0, 4))
            0: return 16'h4000;
            1: return 16'h0000;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_calibration;
        write_reg(REG_ROT_ROW0, {rand_rot(), rand_rot(), rand_rot()});
        write_reg(REG_ROT_ROW1, {rand_rot(), rand_rot(), rand_rot()});
        write_reg(REG_ROT_ROW2, {rand_rot(), rand_rot(), rand_rot()});
        write_reg(REG_TRANSLATION, {16'($urandom), 16'($urandom), 16'($urandom)});
        write_reg(REG_FOCAL_LENGTH, 48'($urandom_range(0, 4095)));
        write_reg(REG_PRINCIPAL_PT, 48'($urandom));
    endtask

    task automatic test_directed;
        send_point(20'd0, 20'd0, 20'd0);
        send_point(20'd256, 20'd0, 20'd0);
        send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);
        send_point(20'h80000, 20'h80000, 20'h80000);
        send_point(20'h7ffff, 20'h80000, 20'h7ffff);
        send_point(20'hfff00, 20'd256, 20'd256);
        send_point(20'd1, 20'h80000, 20'h80000);
        send_point(20'd1, 20'h7ffff, 20'h00000);
        drain();
        write_reg(REG_ROT_ROW0, 48'hffff_ffff_ffff);
        write_reg(REG_ROT_ROW1, 48'h8000_8000_8000);
        write_reg(REG_ROT_ROW2, 48'h7fff_7fff_7fff);
        write_reg(REG_TRANSLATION, 48'h7fff_8000_7fff);
        write_reg(REG_FOCAL_LENGTH, 48'hfff);
        write_reg(REG_PRINCIPAL_PT, 48'hffffff);
        send_point(20'h7ffff, 20'h80000, 20'h80000);
        send_point(20'h80000, 20'h7ffff, 20'h7ffff);
        send_point(20'd0, 20'd0, 20'd0);
        drain();
        write_reg(REG_TRANSLATION, 48'd0);
        write_reg(REG_FOCAL_LENGTH, 48'd0);
        write_reg(REG_PRINCIPAL_PT, 48'd0);
        send_point(20'd0, 20'd5, 20'd5);
        send_point(20'hfffff, 20'd5, 20'd5);
        send_point(20'd1, 20'h7ffff, 20'h80000);
        drain();
    endtask

    task automatic test_random_calibrations;
        repeat (12)
        begin
            random_calibration();
            repeat (110) send_point(rand_coord(), rand_coord(), rand_coord());
            drain();
        end
    endtask

    task automatic test_backpressure;
        write_reg(REG_ROT_ROW0, 48'h4000_0000_0000);
        write_reg(REG_ROT_ROW1, 48'h0000_4000_0000);
        write_reg(REG_ROT_ROW2, 48'h0000_0000_4000);
        write_reg(REG_TRANSLATION, 48'h0100_0000_0000);
        write_reg(REG_FOCAL_LENGTH, 48'd579);
        write_reg(REG_PRINCIPAL_PT, 48'd786736);
        hold_off = 80;
        rx_random = 1'b0;
        repeat (60) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        rx_random = 1'b1;
        repeat (60) send_point(rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (rx_random && rx_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            rx_wait <= $urandom_range(0, 14);
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel u=%h v=%h zd=%b", $time,
                         m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[15:0] !== want.u)
                begin
                    errors++;
                    $display("%0t: pixel_u expected %h actual %h", $time, want.u,
                             m_axis_tdata[15:0]);
                end
                if (m_axis_tdata[31:16] !== want.v)
                begin
                    errors++;
                    $display("%0t: pixel_v expected %h actual %h", $time, want.v,
                             m_axis_tdata[31:16]);
                end
                if (m_axis_tuser !== want.zd)
                begin
                    errors++;
                    $display("%0t: zero_depth expected %b actual %b", $time, want.zd,
                             m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_wen)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rot0 = 48'd70368744177664;
        rot1 = 48'd1073741824;
        rot2 = 48'd16384;
        trans = '0;
        focal = 12'd579;
        ppoint = 24'd786736;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_calibrations();
        test_backpressure();
        if (errors == 0 && pending_pixels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/lppp_pkg.sv
rtl/lppp_rotate.sv
rtl/lppp_numer.sv
rtl/lppp_div.sv
rtl/lidar_point_to_pixel_projector.sv
sim/lidar_point_to_pixel_projector_test.sv
